// ===== hdl/tss_pkg.sv =====
// Shared types, constants and fixed-point helpers of the tridiagonal solver.
package tss_pkg;

  localparam int FX_W       = 48;
  localparam int ROW_IDX_W  = 6;
  localparam int STATUS_W   = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_PIVOT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SATURATED  = 2'd3;

  localparam logic signed [FX_W-1:0] FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
  localparam logic signed [FX_W-1:0] FX_MIN = {1'b1, {(FX_W-1){1'b0}}};

  typedef struct packed {
    logic signed [FX_W-1:0] lower;
    logic signed [FX_W-1:0] diag;
    logic signed [FX_W-1:0] upper;
    logic signed [FX_W-1:0] rhs;
    logic                   last;
  } row_t;

  typedef struct packed {
    logic                   sat;
    logic signed [FX_W-1:0] val;
  } fx_res_t;

  // Magnitude of a signed value; the most negative value maps to 2^47.
  function automatic logic [FX_W-1:0] fx_mag(input logic signed [FX_W-1:0] v);
    return v[FX_W-1] ? (~v + 1'b1) : v;
  endfunction

  // Signed result from magnitude; big flags a magnitude of 2^48 or more.
  function automatic fx_res_t fx_from_mag(input logic [FX_W-1:0] m, input logic big,
                                          input logic neg);
    fx_res_t res;
    res.sat = big | (neg ? (m > {1'b1, {(FX_W-1){1'b0}}}) : m[FX_W-1]);
    if (res.sat) begin
      res.val = neg ? FX_MIN : FX_MAX;
    end else begin
      res.val = neg ? (~m + 1'b1) : m;
    end
    return res;
  endfunction

  function automatic fx_res_t fx_clamp(input logic signed [FX_W:0] v);
    fx_res_t res;
    res.sat = v[FX_W] != v[FX_W-1];
    if (res.sat) begin
      res.val = v[FX_W] ? FX_MIN : FX_MAX;
    end else begin
      res.val = v[FX_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== hdl/tss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tss_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== hdl/tss_front.sv =====
// Input stage: takes row transactions into a short queue for the solver core.
module tss_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tss_pkg::row_t     in_row,
  output logic              q_valid,
  input  logic              q_pop,
  output tss_pkg::row_t     q_row
);
  import tss_pkg::*;

  row_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              push, pop;

  assign in_stall = cnt_r == (QPTR_W+1)'(QUEUE_DEPTH);
  assign q_valid  = cnt_r != '0;
  assign q_row    = mem_r[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= in_row;
  end

endmodule

// ===== hdl/tss_mul.sv =====
// Fixed-point multiplier: four 24x24 partial products accumulated in turn, then scale.
module tss_mul #(
  parameter int FRAC_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [tss_pkg::FX_W-1:0] x,
  input  logic signed [tss_pkg::FX_W-1:0] y,
  output logic                            done,
  output tss_pkg::fx_res_t                res
);
  import tss_pkg::*;

  localparam int HW = FX_W / 2;

  logic [FX_W-1:0]   mx_r, my_r;
  logic              neg_r;
  logic [2:0]        step_r;
  logic              busy_r;
  logic [2*FX_W-1:0] acc_r;
  logic [HW-1:0]     xp, yp;
  logic [FX_W-1:0]   pp;
  logic [6:0]        sh;
  logic [2*FX_W-1:0] pp_sh, scaled;

  assign xp     = step_r[0] ? mx_r[FX_W-1:HW] : mx_r[HW-1:0];
  assign yp     = step_r[1] ? my_r[FX_W-1:HW] : my_r[HW-1:0];
  assign pp     = xp * yp;
  assign sh     = 7'(HW) * (7'(step_r[0]) + 7'(step_r[1]));
  assign pp_sh  = {{FX_W{1'b0}}, pp} << sh;
  assign scaled = acc_r >> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        mx_r   <= fx_mag(x);
        my_r   <= fx_mag(y);
        neg_r  <= x[FX_W-1] ^ y[FX_W-1];
        step_r <= '0;
        acc_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r && step_r != 3'd4) begin
        acc_r  <= acc_r + pp_sh;
        step_r <= step_r + 1'b1;
      end else if (busy_r) begin
        res    <= fx_from_mag(scaled[FX_W-1:0], |scaled[2*FX_W-1:FX_W], neg_r);
        done   <= 1'b1;
        busy_r <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/tss_div.sv =====
// Fixed-point divider: restoring division, one quotient bit per cycle.
module tss_div #(
  parameter int FRAC_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [tss_pkg::FX_W-1:0] num,
  input  logic signed [tss_pkg::FX_W-1:0] den,
  output logic                            done,
  output tss_pkg::fx_res_t                res
);
  import tss_pkg::*;

  localparam int NITER = FX_W + FRAC_BITS;
  localparam int CNT_W = $clog2(NITER + 1);

  logic [FX_W-1:0]  n_r, md_r, r_r;
  logic [FX_W:0]    q_r;
  logic             over_r, neg_r, busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [FX_W:0]    r_sh, r_diff;
  logic             ge;

  assign r_sh   = {r_r, n_r[FX_W-1]};
  assign r_diff = r_sh - {1'b0, md_r};
  assign ge     = r_sh >= {1'b0, md_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        n_r    <= fx_mag(num);
        md_r   <= fx_mag(den);
        neg_r  <= num[FX_W-1] ^ den[FX_W-1];
        r_r    <= '0;
        q_r    <= '0;
        over_r <= 1'b0;
        cnt_r  <= CNT_W'(NITER);
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r != '0) begin
        // keep the remainder below the divisor; any quotient bit past 48 is overflow
        r_r    <= ge ? r_diff[FX_W-1:0] : r_sh[FX_W-1:0];
        q_r    <= {q_r[FX_W-1:0], ge};
        over_r <= over_r | q_r[FX_W];
        n_r    <= n_r << 1;
        cnt_r  <= cnt_r - 1'b1;
      end else if (busy_r) begin
        res    <= fx_from_mag(q_r[FX_W-1:0], over_r | q_r[FX_W], neg_r);
        done   <= 1'b1;
        busy_r <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/tss_back.sv =====
// Solver core: forward elimination per row, back substitution and ordered output.
module tss_back #(
  parameter int MAX_ROWS  = 64,
  parameter int FRAC_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  output logic                                q_pop,
  input  tss_pkg::row_t                       q_row,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tss_pkg::FX_W-1:0]     out_solution,
  output logic [tss_pkg::ROW_IDX_W-1:0]       out_row_index,
  output logic                                out_final_entry,
  output logic [tss_pkg::STATUS_W-1:0]        out_status
);
  import tss_pkg::*;

  localparam int AW = $clog2(MAX_ROWS);

  typedef enum logic [3:0] {
    S_IDLE, S_FW_RD, S_FW_M1, S_FW_M1W, S_FW_M2W, S_PIVOT, S_FW_D1, S_FW_D2,
    S_FW_WR, S_BS_START, S_BS_LD, S_BS_RD, S_BS_M, S_BS_MW, S_EM_RD, S_EM_OUT
  } state_t;

  state_t                 state_r, state_nxt;
  row_t                   row_r, row_nxt;
  logic signed [FX_W-1:0] m_r, m_nxt, num_r, num_nxt, cu_r, cu_nxt, du_r, du_nxt;
  logic signed [FX_W-1:0] x_r, x_nxt, hold_r, hold_nxt;
  logic                   sat_r, sat_nxt;
  logic [AW:0]            rows_r, rows_nxt;
  logic [STATUS_W-1:0]    err_r, err_nxt;
  logic [AW-1:0]          i_r, i_nxt, e_r, e_nxt;
  logic                   ov_nxt, fe_r, fe_nxt;
  logic signed [FX_W-1:0] sol_r, sol_nxt;
  logic [ROW_IDX_W-1:0]   idx_r, idx_nxt;
  logic [STATUS_W-1:0]    st_r, st_nxt;

  logic                   mul_start, mul_done, div_start, div_done;
  logic signed [FX_W-1:0] mul_x, mul_y, div_num, div_den;
  fx_res_t                mul_res, div_res;

  logic                   st_we, x_we;
  logic [AW-1:0]          rd_addr, x_waddr;
  logic [FX_W:0]          x_wdata, x_rdata;
  logic [FX_W-1:0]        cu_rdata, du_rdata;
  logic [AW+ROW_IDX_W-1:0] idx_ext;

  assign rd_addr = (state_r == S_BS_RD) ? (i_r - 1'b1) : AW'(rows_r - 1'b1);
  assign idx_ext = {{ROW_IDX_W{1'b0}}, e_r};

  tss_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .x(mul_x), .y(mul_y),
    .done(mul_done), .res(mul_res)
  );

  tss_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .res(div_res)
  );

  tss_ram #(.WIDTH(FX_W), .DEPTH(MAX_ROWS)) u_cu_ram (
    .clk(clk), .we(st_we), .waddr(rows_r[AW-1:0]), .wdata(cu_r),
    .raddr(rd_addr), .rdata(cu_rdata)
  );

  tss_ram #(.WIDTH(FX_W), .DEPTH(MAX_ROWS)) u_du_ram (
    .clk(clk), .we(st_we), .waddr(rows_r[AW-1:0]), .wdata(du_r),
    .raddr(rd_addr), .rdata(du_rdata)
  );

  tss_ram #(.WIDTH(FX_W+1), .DEPTH(MAX_ROWS)) u_x_ram (
    .clk(clk), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
    .raddr(e_r), .rdata(x_rdata)
  );

  always_comb begin
    fx_res_t cl;
    state_nxt = state_r;
    row_nxt   = row_r;
    m_nxt     = m_r;
    num_nxt   = num_r;
    cu_nxt    = cu_r;
    du_nxt    = du_r;
    x_nxt     = x_r;
    hold_nxt  = hold_r;
    sat_nxt   = sat_r;
    rows_nxt  = rows_r;
    err_nxt   = err_r;
    i_nxt     = i_r;
    e_nxt     = e_r;
    ov_nxt    = out_valid && out_stall;
    fe_nxt    = fe_r;
    sol_nxt   = sol_r;
    idx_nxt   = idx_r;
    st_nxt    = st_r;
    q_pop     = 1'b0;
    mul_start = 1'b0;
    mul_x     = row_r.lower;
    mul_y     = cu_rdata;
    div_start = 1'b0;
    div_num   = num_r;
    div_den   = m_r;
    st_we     = 1'b0;
    x_we      = 1'b0;
    x_waddr   = i_r - 1'b1;
    x_wdata   = {1'b0, x_r};
    cl        = fx_clamp({row_r.diag[FX_W-1], row_r.diag} -
                         {mul_res.val[FX_W-1], mul_res.val});

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          row_nxt = q_row;
          sat_nxt = 1'b0;
          if (rows_r >= (AW+1)'(MAX_ROWS)) begin
            // drop the row; a dropped last row still starts the solve
            if (err_r == ST_OK) err_nxt = ST_TOO_MANY;
            state_nxt = q_row.last ? S_BS_START : S_IDLE;
          end else if (rows_r == '0) begin
            m_nxt     = q_row.diag;
            num_nxt   = q_row.rhs;
            state_nxt = S_PIVOT;
          end else begin
            state_nxt = S_FW_RD;
          end
        end
      end
      S_FW_RD: state_nxt = S_FW_M1;
      S_FW_M1: begin
        mul_start = 1'b1;
        hold_nxt  = du_rdata;
        state_nxt = S_FW_M1W;
      end
      S_FW_M1W: begin
        if (mul_done) begin
          m_nxt     = cl.val;
          sat_nxt   = sat_r | mul_res.sat | cl.sat;
          mul_start = 1'b1;
          mul_y     = hold_r;
          state_nxt = S_FW_M2W;
        end
      end
      S_FW_M2W: begin
        if (mul_done) begin
          cl        = fx_clamp({row_r.rhs[FX_W-1], row_r.rhs} -
                               {mul_res.val[FX_W-1], mul_res.val});
          num_nxt   = cl.val;
          sat_nxt   = sat_r | mul_res.sat | cl.sat;
          state_nxt = S_PIVOT;
        end
      end
      S_PIVOT: begin
        if (m_r == '0) begin
          cu_nxt = '0;
          du_nxt = '0;
          if (err_r == ST_OK) err_nxt = ST_ZERO_PIVOT;
          state_nxt = S_FW_WR;
        end else if (row_r.last) begin
          // the upper coefficient of the last row counts as zero
          cu_nxt    = '0;
          div_start = 1'b1;
          state_nxt = S_FW_D2;
        end else begin
          div_start = 1'b1;
          div_num   = row_r.upper;
          state_nxt = S_FW_D1;
        end
      end
      S_FW_D1: begin
        if (div_done) begin
          cu_nxt    = div_res.val;
          sat_nxt   = sat_r | div_res.sat;
          div_start = 1'b1;
          state_nxt = S_FW_D2;
        end
      end
      S_FW_D2: begin
        if (div_done) begin
          du_nxt    = div_res.val;
          sat_nxt   = sat_r | div_res.sat;
          state_nxt = S_FW_WR;
        end
      end
      S_FW_WR: begin
        st_we = 1'b1;
        if (sat_r && err_r == ST_OK) err_nxt = ST_SATURATED;
        rows_nxt  = rows_r + 1'b1;
        state_nxt = row_r.last ? S_BS_START : S_IDLE;
      end
      S_BS_START: state_nxt = S_BS_LD;
      S_BS_LD: begin
        x_nxt   = du_rdata;
        x_we    = 1'b1;
        x_waddr = AW'(rows_r - 1'b1);
        x_wdata = {1'b0, du_rdata};
        i_nxt   = AW'(rows_r - 1'b1);
        e_nxt   = '0;
        state_nxt = (rows_r == (AW+1)'(1)) ? S_EM_RD : S_BS_RD;
      end
      S_BS_RD: state_nxt = S_BS_M;
      S_BS_M: begin
        mul_start = 1'b1;
        mul_x     = cu_rdata;
        mul_y     = x_r;
        hold_nxt  = du_rdata;
        state_nxt = S_BS_MW;
      end
      S_BS_MW: begin
        if (mul_done) begin
          cl        = fx_clamp({hold_r[FX_W-1], hold_r} -
                               {mul_res.val[FX_W-1], mul_res.val});
          x_nxt     = cl.val;
          x_we      = 1'b1;
          x_wdata   = {mul_res.sat | cl.sat, cl.val};
          i_nxt     = i_r - 1'b1;
          state_nxt = (i_r == AW'(1)) ? S_EM_RD : S_BS_RD;
        end
      end
      S_EM_RD: state_nxt = S_EM_OUT;
      S_EM_OUT: begin
        if (!out_valid || !out_stall) begin
          ov_nxt  = 1'b1;
          sol_nxt = x_rdata[FX_W-1:0];
          idx_nxt = idx_ext[ROW_IDX_W-1:0];
          fe_nxt  = {1'b0, e_r} == rows_r - 1'b1;
          if (err_r != ST_OK) begin
            st_nxt = err_r;
          end else begin
            st_nxt = x_rdata[FX_W] ? ST_SATURATED : ST_OK;
          end
          if ({1'b0, e_r} == rows_r - 1'b1) begin
            rows_nxt  = '0;
            err_nxt   = ST_OK;
            state_nxt = S_IDLE;
          end else begin
            e_nxt     = e_r + 1'b1;
            state_nxt = S_EM_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rows_r    <= '0;
      err_r     <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rows_r    <= rows_nxt;
      err_r     <= err_nxt;
      out_valid <= ov_nxt;
    end
    row_r  <= row_nxt;
    m_r    <= m_nxt;
    num_r  <= num_nxt;
    cu_r   <= cu_nxt;
    du_r   <= du_nxt;
    x_r    <= x_nxt;
    hold_r <= hold_nxt;
    sat_r  <= sat_nxt;
    i_r    <= i_nxt;
    e_r    <= e_nxt;
    fe_r   <= fe_nxt;
    sol_r  <= sol_nxt;
    idx_r  <= idx_nxt;
    st_r   <= st_nxt;
  end

  assign out_solution    = sol_r;
  assign out_row_index   = idx_r;
  assign out_final_entry = fe_r;
  assign out_status      = st_r;

endmodule

// ===== hdl/tridiagonal_system_solver.sv =====
// Top level of the tridiagonal system solver (Thomas algorithm, signed fixed point).
// Rows enter one per input transaction into a four-deep queue; the core eliminates
// each row as it is taken (the first row of a system needs no multiplies, and the
// last row needs one quotient fewer), using the single bit-per-cycle divider that
// forms both quotients of a row in turn. After the row flagged last, back
// substitution runs row by row through the shared four-step multiplier, and the
// solution entries leave in index order, the final one flagged. Rows beyond MAX_ROWS
// are dropped and reported in status. No clearing pass is needed after reset.
module tridiagonal_system_solver #(
  parameter int MAX_ROWS  = 64,
  parameter int FRAC_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [tss_pkg::FX_W-1:0]     in_lower_coef,
  input  logic signed [tss_pkg::FX_W-1:0]     in_diag_coef,
  input  logic signed [tss_pkg::FX_W-1:0]     in_upper_coef,
  input  logic signed [tss_pkg::FX_W-1:0]     in_rhs_value,
  input  logic                                in_last_row,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tss_pkg::FX_W-1:0]     out_solution,
  output logic [tss_pkg::ROW_IDX_W-1:0]       out_row_index,
  output logic                                out_final_entry,
  output logic [tss_pkg::STATUS_W-1:0]        out_status
);
  import tss_pkg::*;

  row_t in_row, q_row;
  logic q_valid, q_pop;

  assign in_row = '{lower: in_lower_coef, diag: in_diag_coef, upper: in_upper_coef,
                    rhs: in_rhs_value, last: in_last_row};

  tss_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_row(in_row), .q_valid(q_valid), .q_pop(q_pop), .q_row(q_row)
  );

  tss_back #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_row(q_row),
    .out_valid(out_valid), .out_stall(out_stall), .out_solution(out_solution),
    .out_row_index(out_row_index), .out_final_entry(out_final_entry),
    .out_status(out_status)
  );

endmodule

// ===== hdl/tss_checker.sv =====
// Port-level assertions for the tridiagonal solver, bound to the top level.
module tss_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic signed [tss_pkg::FX_W-1:0] out_solution,
  input logic                            out_final_entry
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_solution))
    else $error("stalled result changed or dropped");

  // queue can only fill on an accepted row
  a_stall_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid))
    else $error("input stall rose without a transaction");

  // after the final entry leaves, the core is back to taking rows
  a_final_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_final_entry |=> !out_valid)
    else $error("result shown right after final entry");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset left handshake outputs active");

endmodule

bind tridiagonal_system_solver tss_checker u_tss_checker (.*);
